// ===== rtl/core/tsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Tagged slot allocator package
// Shared widths, codes, the tag record layout and the sequencer state type.
// ----------------------------------------------------------------------------
package tsa_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);

    localparam int OP_W    = 2;
    localparam int VOL_W   = 8;
    localparam int CLS_W   = 4;
    localparam int TYPE_W  = 5;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 6;
    localparam int CNT_W   = 6;
    localparam int TAG_W   = VOL_W + CLS_W + TYPE_W;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = STAT_W + 1;

    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_REFUSED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MOVIE_CLASS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TS_CLASS    = 1'd1;

    localparam logic [CLS_W-1:0] MOVIE_CLASS_RESET = 4'd2;
    localparam logic [CLS_W-1:0] TS_CLASS_RESET    = 4'd3;

    typedef struct packed {
        logic [VOL_W-1:0]  vol;
        logic [CLS_W-1:0]  cls;
        logic [TYPE_W-1:0] ftype;
    } tag_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ALLOC  = 4'b0010,
        S_WALK   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

endpackage

// ===== rtl/core/tsa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module tsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/tagged_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// Tagged slot allocator
// Slot table with a linked LIFO free list, volume release and tag queries.
// ----------------------------------------------------------------------------
// The block keeps a table of record slots, each holding a used mark, a volume
// tag, a class code and a file type, and hands slots out from a LIFO free
// list. One request is handled at a time and s_tready is high only while the
// block is idle. An allocate request that finds a free slot passes from
// the idle state through S_ALLOC, where the head slot is popped and tagged,
// to S_FINISH, where its result is presented. An allocate on a full table,
// a refused (plugged) release and the spare op code skip straight to
// S_FINISH and their single result. Other release requests and all query
// requests scan every slot through the single read port of the tag memory,
// one slot per cycle while no query match waits on a stalled result channel.
// Every request is held up while its result waits on a stalled channel. A
// query returns one result per matching slot with tlast on the final one, or
// a single empty result with tlast when nothing matches. The last slot of the
// chain is never handed out, so ENTRIES - 1 slots are usable. No clearing
// pass is needed after reset: used marks and link-written marks are
// flip-flops cleared by reset.
// ----------------------------------------------------------------------------
module tagged_slot_allocator (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input requests.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata: volume[7:0], class_code[11:8], ftype[16:12], plugged[17]
    input  logic [tsa_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser: op[1:0]
    input  logic [tsa_pkg::S_TUSER_W-1:0]    s_tuser,
    // Results.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: slot[5:0], slot_type[10:6], slot_class[14:11], match_count[20:15]
    output logic [tsa_pkg::M_TDATA_W-1:0]    m_tdata,
    // tuser: status[1:0], found[2]
    output logic [tsa_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                             m_tlast,
    // Configuration writes.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tsa_pkg::CLS_W-1:0]        cfg_data
);

    import tsa_pkg::*;

    // Sequencer and table state.
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [ENTRIES-1:0] used_reg, used_next;
    logic [ENTRIES-1:0] link_vld_reg, link_vld_next;

    // Configuration registers.
    logic [CLS_W-1:0]   movie_class_reg;
    logic [CLS_W-1:0]   ts_class_reg;

    // Latched request.
    logic [OP_W-1:0]    op_reg, op_next;
    logic [VOL_W-1:0]   vol_reg, vol_next;
    logic [CLS_W-1:0]   cls_reg, cls_next;
    logic [TYPE_W-1:0]  ftype_reg, ftype_next;

    // Query match held back until we know whether it is the final one.
    logic               pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]   pend_slot_reg, pend_slot_next;
    logic [TYPE_W-1:0]  pend_type_reg, pend_type_next;
    logic [CLS_W-1:0]   pend_cls_reg, pend_cls_next;
    logic [CNT_W-1:0]   pend_cnt_reg, pend_cnt_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // Final result of the request.
    logic [STAT_W-1:0]  fin_status_reg, fin_status_next;
    logic [IDX_W-1:0]   fin_slot_reg, fin_slot_next;

    // Output register.
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic                 m_tlast_reg, m_tlast_next;

    // Memory ports.
    logic               tag_we;
    logic [IDX_W-1:0]   tag_waddr;
    tag_t               tag_wdata;
    logic [IDX_W-1:0]   tag_raddr;
    tag_t               tag_rdata;
    logic               link_we;
    logic [IDX_W-1:0]   link_waddr;
    logic [IDX_W-1:0]   link_wdata;
    logic [IDX_W-1:0]   link_rdata;

    // Request fields.
    logic [OP_W-1:0]    in_op;
    logic [VOL_W-1:0]   in_vol;
    logic [CLS_W-1:0]   in_cls;
    logic [TYPE_W-1:0]  in_ftype;
    logic               in_plugged;

    logic               s_accept;
    logic               out_free;
    logic               out_load;
    logic [STAT_W-1:0]  out_status;
    logic [IDX_W-1:0]   out_slot;
    logic               out_found;
    logic [TYPE_W-1:0]  out_type;
    logic [CLS_W-1:0]   out_cls;
    logic [CNT_W-1:0]   out_cnt;
    logic               out_last;

    logic               vol_hit;
    logic               cls_hit;
    logic               advance;

    assign in_vol     = s_tdata[VOL_W-1:0];
    assign in_cls     = s_tdata[VOL_W +: CLS_W];
    assign in_ftype   = s_tdata[VOL_W + CLS_W +: TYPE_W];
    assign in_plugged = s_tdata[VOL_W + CLS_W + TYPE_W];
    assign in_op      = s_tuser;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // The slot under the scan pointer: its tags come from the tag memory,
    // read in the cycle before, and its used mark from the flip-flops.
    assign vol_hit = used_reg[idx_reg] && (tag_rdata.vol == vol_reg);
    assign cls_hit = (tag_rdata.cls == cls_reg) ||
                     ((cls_reg == movie_class_reg) && (tag_rdata.cls == ts_class_reg));

    tsa_ram #(
        .WIDTH (TAG_W),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    // Free-list links. A link never written reads as "next slot up", which
    // is the chain that reset sets up.
    tsa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (ENTRIES)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (head_reg),
        .rdata (link_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        head_next       = head_reg;
        used_next       = used_reg;
        link_vld_next   = link_vld_reg;
        op_next         = op_reg;
        vol_next        = vol_reg;
        cls_next        = cls_reg;
        ftype_next      = ftype_reg;
        pend_vld_next   = pend_vld_reg;
        pend_slot_next  = pend_slot_reg;
        pend_type_next  = pend_type_reg;
        pend_cls_next   = pend_cls_reg;
        pend_cnt_next   = pend_cnt_reg;
        cnt_next        = cnt_reg;
        fin_status_next = fin_status_reg;
        fin_slot_next   = fin_slot_reg;

        tag_we     = 1'b0;
        tag_waddr  = head_reg;
        tag_wdata  = '{vol: vol_reg, cls: cls_reg, ftype: ftype_reg};
        tag_raddr  = '0;
        link_we    = 1'b0;
        link_waddr = idx_reg;
        link_wdata = head_reg;
        advance    = 1'b1;

        out_load   = 1'b0;
        out_status = ST_OK;
        out_slot   = '0;
        out_found  = 1'b0;
        out_type   = '0;
        out_cls    = '0;
        out_cnt    = '0;
        out_last   = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    op_next         = in_op;
                    vol_next        = in_vol;
                    cls_next        = in_cls;
                    ftype_next      = in_ftype;
                    pend_vld_next   = 1'b0;
                    cnt_next        = '0;
                    idx_next        = '0;
                    fin_status_next = ST_OK;
                    fin_slot_next   = '0;
                    case (in_op)
                        OP_ALLOC: begin
                            // The tail slot is never handed out.
                            if (head_reg == IDX_W'(ENTRIES - 1)) begin
                                fin_status_next = ST_FULL;
                                state_next      = S_FINISH;
                            end else begin
                                state_next = S_ALLOC;
                            end
                        end
                        OP_RELEASE: begin
                            if (in_plugged) begin
                                fin_status_next = ST_REFUSED;
                                state_next      = S_FINISH;
                            end else begin
                                state_next = S_WALK;
                            end
                        end
                        OP_QUERY: begin
                            state_next = S_WALK;
                        end
                        default: begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_ALLOC: begin
                // The link of the head slot was read while the request was
                // accepted; pop the head and tag the slot.
                tag_we            = 1'b1;
                used_next[head_reg] = 1'b1;
                fin_slot_next     = head_reg;
                if (link_vld_reg[head_reg]) begin
                    head_next = link_rdata;
                end else begin
                    head_next = IDX_W'(head_reg + 1'b1);
                end
                state_next = S_FINISH;
            end

            S_WALK: begin
                if (op_reg == OP_RELEASE) begin
                    if (vol_hit) begin
                        // Push the slot onto the free list.
                        link_we               = 1'b1;
                        link_vld_next[idx_reg] = 1'b1;
                        head_next             = idx_reg;
                        used_next[idx_reg]    = 1'b0;
                    end
                end else if (vol_hit && cls_hit) begin
                    if (pend_vld_reg && !out_free) begin
                        advance = 1'b0;
                    end else begin
                        if (pend_vld_reg) begin
                            // A later match exists, so the held one is not last.
                            out_load  = 1'b1;
                            out_slot  = pend_slot_reg;
                            out_found = 1'b1;
                            out_type  = pend_type_reg;
                            out_cls   = pend_cls_reg;
                            out_cnt   = pend_cnt_reg;
                            out_last  = 1'b0;
                        end
                        pend_vld_next  = 1'b1;
                        pend_slot_next = idx_reg;
                        pend_type_next = tag_rdata.ftype;
                        pend_cls_next  = tag_rdata.cls;
                        pend_cnt_next  = CNT_W'(cnt_reg + 1'b1);
                        cnt_next       = CNT_W'(cnt_reg + 1'b1);
                    end
                end

                // Read the next slot ahead, or hold the current one on a stall.
                if (advance) begin
                    tag_raddr = IDX_W'(idx_reg + 1'b1);
                    if (idx_reg == IDX_W'(ENTRIES - 1)) begin
                        state_next = S_FINISH;
                    end else begin
                        idx_next = IDX_W'(idx_reg + 1'b1);
                    end
                end else begin
                    tag_raddr = idx_reg;
                end
            end

            S_FINISH: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = fin_status_reg;
                    out_last   = 1'b1;
                    if (pend_vld_reg) begin
                        out_slot  = pend_slot_reg;
                        out_found = 1'b1;
                        out_type  = pend_type_reg;
                        out_cls   = pend_cls_reg;
                        out_cnt   = pend_cnt_reg;
                    end else begin
                        out_slot = fin_slot_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: a new result loads whenever the old one is gone or
    // is being taken in the same cycle.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {3'b000, out_cnt, out_cls, out_type, SLOT_W'(out_slot)};
            m_tuser_next  = {out_found, out_status};
            m_tlast_next  = out_last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            used_reg        <= '0;
            link_vld_reg    <= '0;
            pend_vld_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            movie_class_reg <= MOVIE_CLASS_RESET;
            ts_class_reg    <= TS_CLASS_RESET;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            used_reg     <= used_next;
            link_vld_reg <= link_vld_next;
            pend_vld_reg <= pend_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MOVIE_CLASS: movie_class_reg <= cfg_data;
                    CFG_TS_CLASS:    ts_class_reg    <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        op_reg         <= op_next;
        vol_reg        <= vol_next;
        cls_reg        <= cls_next;
        ftype_reg      <= ftype_next;
        pend_slot_reg  <= pend_slot_next;
        pend_type_reg  <= pend_type_next;
        pend_cls_reg   <= pend_cls_next;
        pend_cnt_reg   <= pend_cnt_next;
        cnt_reg        <= cnt_next;
        fin_status_reg <= fin_status_next;
        fin_slot_reg   <= fin_slot_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
        m_tlast_reg    <= m_tlast_next;
    end

endmodule

// ===== rtl/core/tsa_checker.sv =====
// ----------------------------------------------------------------------------
// Tagged slot allocator checker
// Port-level assertions on request acceptance and result framing.
// ----------------------------------------------------------------------------
module tsa_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tsa_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [tsa_pkg::M_TUSER_W-1:0]    m_tuser,
    input logic                             m_tlast
);

    import tsa_pkg::*;

    // One request at a time: the block is busy right after taking one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while the previous one is in progress");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // Errors are single results that carry no slot match.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[STAT_W-1:0] != ST_OK) |-> m_tlast && !m_tuser[STAT_W])
        else $error("error result not final or marked found");

    // Only query matches can be followed by further results of the request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[STAT_W] && (m_tuser[STAT_W-1:0] == ST_OK))
        else $error("non-final result is not a query match");

endmodule

bind tagged_slot_allocator tsa_checker u_tsa_checker (.*);

// ===== tb/sv/tsa_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged slot allocator checker
// Request and result records plus a class that mirrors the slot table, the
// free list and the class registers, and checks each result in order.
// ----------------------------------------------------------------------------
package tsa_tb_pkg;

    import tsa_pkg::*;

    // The op field has one spare code. The block answers it with an empty result.
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [VOL_W-1:0]  vol;
        logic [CLS_W-1:0]  cls;
        logic [TYPE_W-1:0] ftype;
        logic              plugged;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic              found;
        logic [TYPE_W-1:0] stype;
        logic [CLS_W-1:0]  sclass;
        logic [CNT_W-1:0]  count;
        logic              last;
    } outcome_t;

    class slot_table_checker;

        logic [IDX_W-1:0]  next_free [ENTRIES];
        logic [IDX_W-1:0]  head;
        logic              busy      [ENTRIES];
        logic [VOL_W-1:0]  vol_of    [ENTRIES];
        logic [CLS_W-1:0]  cls_of    [ENTRIES];
        logic [TYPE_W-1:0] type_of   [ENTRIES];
        logic [CLS_W-1:0]  movie_cls;
        logic [CLS_W-1:0]  ts_cls;

        outcome_t due_records[$];
        int       errors;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                next_free[i] = IDX_W'((i + 1) % ENTRIES);
                busy[i]      = 1'b0;
                vol_of[i]    = '0;
                cls_of[i]    = '0;
                type_of[i]   = '0;
            end
            head      = '0;
            movie_cls = MOVIE_CLASS_RESET;
            ts_cls    = TS_CLASS_RESET;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CLS_W-1:0] val);
            case (idx)
                CFG_MOVIE_CLASS: movie_cls = val;
                CFG_TS_CLASS:    ts_cls = val;
                default:         ;
            endcase
        endfunction

        // A single closing result: only status, slot and last may be nonzero.
        function outcome_t closing(logic [STAT_W-1:0] status, logic [SLOT_W-1:0] slot);
            outcome_t o;
            o        = '0;
            o.status = status;
            o.slot   = slot;
            o.last   = 1'b1;
            return o;
        endfunction

        // Updates the mirrored table for one accepted request and queues the
        // results that the block has to return for it.
        function void apply_request(request_t r);
            logic [IDX_W-1:0] taken;
            logic             also_ts;
            outcome_t         held;
            int               n;
            case (r.op)
                OP_ALLOC: begin
                    if (head == IDX_W'(ENTRIES - 1)) begin
                        due_records.push_back(closing(ST_FULL, '0));
                    end else begin
                        taken          = head;
                        head           = next_free[taken];
                        busy[taken]    = 1'b1;
                        vol_of[taken]  = r.vol;
                        cls_of[taken]  = r.cls;
                        type_of[taken] = r.ftype;
                        due_records.push_back(closing(ST_OK, taken));
                    end
                end
                OP_RELEASE: begin
                    if (r.plugged) begin
                        due_records.push_back(closing(ST_REFUSED, '0));
                    end else begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (busy[i] && vol_of[i] == r.vol) begin
                                next_free[i] = head;
                                head         = IDX_W'(i);
                                busy[i]      = 1'b0;
                                vol_of[i]    = '0;
                                cls_of[i]    = '0;
                                type_of[i]   = '0;
                            end
                        end
                        due_records.push_back(closing(ST_OK, '0));
                    end
                end
                OP_QUERY: begin
                    also_ts = (r.cls == movie_cls);
                    n       = 0;
                    held    = '0;
                    // Each hit is held back one step so that the final one can
                    // carry the last flag.
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (busy[i] && vol_of[i] == r.vol &&
                            (cls_of[i] == r.cls || (also_ts && cls_of[i] == ts_cls))) begin
                            if (n > 0)
                                due_records.push_back(held);
                            n            = n + 1;
                            held         = '0;
                            held.slot    = SLOT_W'(i);
                            held.found   = 1'b1;
                            held.stype   = type_of[i];
                            held.sclass  = cls_of[i];
                            held.count   = CNT_W'(n);
                        end
                    end
                    if (n == 0) begin
                        due_records.push_back(closing(ST_OK, '0));
                    end else begin
                        held.last = 1'b1;
                        due_records.push_back(held);
                    end
                end
                default: begin
                    due_records.push_back(closing(ST_OK, '0));
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("[tb] %0t ns mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want, int slot);
            if (got !== want)
                report($sformatf("%s is %0d, should be %0d (slot %0d)", name, got, want, slot));
        endtask

        task match_record(outcome_t got);
            outcome_t want;
            if (due_records.size() == 0) begin
                report($sformatf("result for slot %0d arrived with nothing due", got.slot));
                return;
            end
            want = due_records.pop_front();
            compare_field("status", 8'(got.status), 8'(want.status), want.slot);
            compare_field("slot", 8'(got.slot), 8'(want.slot), want.slot);
            compare_field("found", 8'(got.found), 8'(want.found), want.slot);
            compare_field("slot_type", 8'(got.stype), 8'(want.stype), want.slot);
            compare_field("slot_class", 8'(got.sclass), 8'(want.sclass), want.slot);
            compare_field("match_count", 8'(got.count), 8'(want.count), want.slot);
            compare_field("last", 8'(got.last), 8'(want.last), want.slot);
        endtask

    endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged slot allocator testbench
// Drives allocate, release, query and spare-op requests through the stream
// ports, mirrors the slot table in a checker and compares every result.
// ----------------------------------------------------------------------------
module tb;

    import tsa_pkg::*;
    import tsa_tb_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CLS_W-1:0]     cfg_data;

    slot_table_checker chk = new();

    // The stimulus asks for a long result stall by bumping hold_req. The
    // receiver process notices the change and counts the stall out itself.
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int ready_cycle = 0;
    int burst_left  = 0;

    outcome_t seen_result;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    tagged_slot_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Result side back-pressure. Outside a long hold the receiver cycles
    // through three moods in turn: always ready, coin-flip ready, and mostly
    // ready with evenly spaced stalls. The coin-flip mood puts random stalls
    // among the beats of a long query answer.
    always @(posedge aclk) begin
        ready_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = 400;
            m_tready <= 1'b0;
        end else begin
            case ((ready_cycle / 150) % 3)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(1) == 1);
                default: m_tready <= (ready_cycle % 5 != 0);
            endcase
        end
    end

    // Every result handshake is unpacked and checked against the oldest
    // result still due. The outputs are sampled at the edge, before the
    // block's own updates for that edge land.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid && m_tready) begin
            seen_result.status = m_tuser[1:0];
            seen_result.found  = m_tuser[2];
            seen_result.slot   = m_tdata[5:0];
            seen_result.stype  = m_tdata[10:6];
            seen_result.sclass = m_tdata[14:11];
            seen_result.count  = m_tdata[20:15];
            seen_result.last   = m_tlast;
            chk.match_record(seen_result);
        end
    end

    function automatic request_t request_of(logic [OP_W-1:0] op, logic [VOL_W-1:0] vol,
                                            logic [CLS_W-1:0] cls, logic [TYPE_W-1:0] ftype,
                                            logic plugged);
        request_t r;
        r.op      = op;
        r.vol     = vol;
        r.cls     = cls;
        r.ftype   = ftype;
        r.plugged = plugged;
        return r;
    endfunction

    // Classes lean toward the two special codes so that the movie/ts
    // matching rule is exercised often.
    function automatic logic [CLS_W-1:0] pick_class();
        int k;
        k = $urandom_range(9);
        if (k < 4)
            return chk.movie_cls;
        if (k < 6)
            return chk.ts_cls;
        return CLS_W'($urandom_range(15));
    endfunction

    // Volumes come mostly from a pool of four so that queries find several
    // hits and releases free whole groups of slots. The rest is noise.
    function automatic request_t random_request();
        request_t r;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 40)
            r.op = OP_ALLOC;
        else if (pick < 75)
            r.op = OP_QUERY;
        else if (pick < 95)
            r.op = OP_RELEASE;
        else
            r.op = OP_NONE;
        if ($urandom_range(99) < 85)
            r.vol = VOL_W'($urandom_range(3));
        else
            r.vol = VOL_W'($urandom_range(255));
        r.cls     = pick_class();
        r.ftype   = TYPE_W'($urandom_range(31));
        r.plugged = ($urandom_range(99) < 30);
        return r;
    endfunction

    // Presents one request and holds it until the block takes it. The valid
    // line is left high, so back-to-back requests never toggle it.
    task automatic push_request(request_t r);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, r.plugged, r.ftype, r.cls, r.vol};
        s_tuser  <= r.op;
        do @(posedge aclk); while (!s_tready);
        chk.apply_request(r);
    endtask

    // The sender works in bursts. Between bursts it drops valid for a random
    // gap; a zero-length gap gives stretches with no idling at all.
    task automatic offer(request_t r);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        push_request(r);
        burst_left--;
    endtask

    // Stops offering requests until every result due has come back, then
    // lets the clock run on until the block is surely idle.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (chk.due_records.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CLS_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        chk.write_reg(idx, val);
    endtask

    task automatic configure(logic [CLS_W-1:0] movie, logic [CLS_W-1:0] ts);
        settle();
        write_reg(CFG_MOVIE_CLASS, movie);
        write_reg(CFG_TS_CLASS, ts);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count);
        repeat (count) offer(random_request());
    endtask

    initial begin
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with the reset class registers (movie 2, ts 3).
        // Slots 0 to 4 are tagged with field extremes and a small group on
        // volume 7 that mixes the movie, ts and an ordinary class.
        offer(request_of(OP_ALLOC, 8'd0, 4'd0, 5'd0, 1'b0));
        offer(request_of(OP_ALLOC, 8'd255, 4'd15, 5'd31, 1'b1));
        offer(request_of(OP_ALLOC, 8'd7, 4'd2, 5'd5, 1'b0));
        offer(request_of(OP_ALLOC, 8'd7, 4'd3, 5'd9, 1'b0));
        offer(request_of(OP_ALLOC, 8'd7, 4'd4, 5'd1, 1'b0));
        // A movie query also picks up the ts slot; a ts query does not
        // pick up the movie slot.
        offer(request_of(OP_QUERY, 8'd7, 4'd2, 5'd0, 1'b0));
        offer(request_of(OP_QUERY, 8'd7, 4'd3, 5'd0, 1'b0));
        offer(request_of(OP_QUERY, 8'd7, 4'd4, 5'd0, 1'b0));
        offer(request_of(OP_QUERY, 8'd9, 4'd2, 5'd0, 1'b0));
        offer(request_of(OP_QUERY, 8'd255, 4'd15, 5'd31, 1'b1));
        offer(request_of(OP_QUERY, 8'd0, 4'd0, 5'd0, 1'b0));
        // A plugged release is refused and leaves the table alone.
        offer(request_of(OP_RELEASE, 8'd7, 4'd0, 5'd0, 1'b1));
        offer(request_of(OP_RELEASE, 8'd7, 4'd0, 5'd0, 1'b0));
        offer(request_of(OP_QUERY, 8'd7, 4'd2, 5'd0, 1'b0));
        offer(request_of(OP_RELEASE, 8'd200, 4'd0, 5'd0, 1'b0));
        offer(request_of(OP_NONE, 8'd255, 4'd15, 5'd31, 1'b1));
        // The free list is LIFO, so this takes the last slot pushed back.
        offer(request_of(OP_ALLOC, 8'd7, 4'd3, 5'd17, 1'b0));
        offer(request_of(OP_RELEASE, 8'd0, 4'd0, 5'd0, 1'b0));
        offer(request_of(OP_RELEASE, 8'd255, 4'd15, 5'd31, 1'b0));

        // Fill the table past full while the receiver holds off for a long
        // stretch, so the block backs up and stalls its input side.
        configure(4'd15, 4'd0);
        hold_req++;
        repeat (70)
            offer(request_of(OP_ALLOC, VOL_W'(1 + $urandom_range(2)), pick_class(),
                             TYPE_W'($urandom_range(31)), 1'($urandom_range(1))));
        for (int v = 1; v <= 3; v++) begin
            offer(request_of(OP_QUERY, VOL_W'(v), chk.movie_cls, 5'd0, 1'b0));
            offer(request_of(OP_QUERY, VOL_W'(v), chk.ts_cls, 5'd0, 1'b0));
            offer(request_of(OP_QUERY, VOL_W'(v), CLS_W'($urandom_range(15)), 5'd0, 1'b0));
        end
        offer(request_of(OP_RELEASE, 8'd2, 4'd0, 5'd0, 1'b1));
        for (int v = 1; v <= 3; v++)
            offer(request_of(OP_RELEASE, VOL_W'(v), 4'd0, 5'd0, 1'b0));
        random_phase(70);

        // Random mixes under the other register extremes, with movie and ts
        // equal, and back at the reset values.
        configure(4'd0, 4'd15);
        random_phase(70);
        configure(4'd5, 4'd5);
        random_phase(70);
        configure(MOVIE_CLASS_RESET, TS_CLASS_RESET);
        random_phase(70);

        settle();
        if (chk.errors == 0 && chk.due_records.size() == 0)
            $display("[tagged_slot_allocator] OK");
        else
            $display("[tagged_slot_allocator] ERROR");
        $finish;
    end

    // Guard against a hung handshake. The bound is many times the slowest
    // legal run: every query answering 63 hits under heavy back-pressure.
    initial begin
        #50_000_000;
        $display("[tagged_slot_allocator] ERROR");
        $finish;
    end

endmodule
